>>> rtl/core/scpa_pkg.sv
// shared types, constants and class lookup functions of the size class pool allocator
package scpa_pkg;

   // pool geometry defaults
   localparam int REGION_BYTES_DEF = 16384;
   localparam int REGION_COUNT_DEF = 16;
   localparam int LARGEST_PIECE    = 4096;
   localparam int CLASS_COUNT      = 35;
   localparam int SMALLEST_PIECE   = 8;

   // field widths
   localparam int ADDR_W   = 18;
   localparam int BYTES_W  = 24;
   localparam int GRANT_W  = 13;
   localparam int STATUS_W = 3;
   localparam int CLASS_W  = $clog2(CLASS_COUNT);
   localparam int LINK_AW  = 16;
   localparam int REST_W   = 21;
   localparam int UNIT_W   = 11;

   localparam logic [ADDR_W-1:0] WASTE_MAX = '1;

   // request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FREED     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;

   // class sizes in 4-byte units
   localparam logic [UNIT_W-1:0] UNIT_TABLE [CLASS_COUNT] = '{
      11'd1, 11'd2, 11'd3, 11'd4, 11'd5, 11'd6, 11'd7, 11'd8, 11'd9, 11'd10,
      11'd11, 11'd12, 11'd13, 11'd14, 11'd15, 11'd16, 11'd18, 11'd19, 11'd20,
      11'd24, 11'd32, 11'd40, 11'd48, 11'd64, 11'd80, 11'd128, 11'd160,
      11'd256, 11'd320, 11'd384, 11'd512, 11'd640, 11'd768, 11'd896, 11'd1024
   };

   typedef struct packed {
      logic                req_type;
      logic [BYTES_W-1:0]  request_bytes;
      logic [ADDR_W-1:0]   piece_address;
   } req_word_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   granted_address;
      logic [GRANT_W-1:0]  granted_bytes;
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   wasted_total;
   } rsp_word_type;

   // granted bytes of a class, bumped up to the first class reaching the smallest piece
   function automatic logic [GRANT_W-1:0] class_bytes(input logic [CLASS_W-1:0] idx);
      logic [GRANT_W-1:0] res;
      logic               done;
      res  = {UNIT_TABLE[CLASS_COUNT-1], 2'b00};
      done = 1'b0;
      for (int k = 0; k < CLASS_COUNT; k++) begin
         if (!done && (CLASS_W'(k) >= idx) &&
             ({UNIT_TABLE[k], 2'b00} >= GRANT_W'(SMALLEST_PIECE))) begin
            res  = {UNIT_TABLE[k], 2'b00};
            done = 1'b1;
         end
      end
      return res;
   endfunction

   // smallest class holding a byte count of at most the largest piece
   function automatic logic [CLASS_W-1:0] class_for(input logic [GRANT_W-1:0] nbytes);
      logic [GRANT_W:0]   sum;
      logic [UNIT_W:0]    units;
      logic [CLASS_W-1:0] res;
      sum   = {1'b0, nbytes} + (GRANT_W+1)'(3);
      units = sum[GRANT_W:2];
      res   = CLASS_W'(CLASS_COUNT - 1);
      for (int k = CLASS_COUNT - 1; k >= 0; k--) begin
         if ({1'b0, UNIT_TABLE[k]} >= units) begin
            res = CLASS_W'(k);
         end
      end
      return res;
   endfunction

   // largest class whose granted size fits into the remaining tail
   function automatic logic [CLASS_W-1:0] pick_class(input logic [REST_W-1:0] rest);
      logic [CLASS_W-1:0] res;
      res = '0;
      for (int k = 0; k < CLASS_COUNT; k++) begin
         if (REST_W'(class_bytes(CLASS_W'(k))) <= rest) begin
            res = CLASS_W'(k);
         end
      end
      return res;
   endfunction

endpackage

>>> rtl/core/size_class_pool_allocator_top.sv
// size class pool allocator: free list heads and links in rams, bump and tail carving
// paths: zero or oversize go straight to the result; free reads the head, then pushes;
//   pop reads the head, then the link; bump reads the head; region change carves the tail into pieces, then opens
// throughput: one word at a time, next request taken once the result is registered
// reset: synchronous, clears list valid bits, region count, offset and waste count;
//   link words are undefined until a push writes them, no clearing pass
module size_class_pool_allocator_top
   #(
   parameter int REGION_BYTES = scpa_pkg::REGION_BYTES_DEF,
   parameter int REGION_COUNT = scpa_pkg::REGION_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  scpa_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output scpa_pkg::rsp_word_type rsp_word
);
   import scpa_pkg::*;

   localparam int OFS_W = $clog2(REGION_BYTES + 1);
   localparam int RGN_W = $clog2(REGION_COUNT + 1);
   localparam logic [OFS_W-1:0]  RB_OFS  = OFS_W'(REGION_BYTES);
   localparam logic [ADDR_W-1:0] RB_ADDR = ADDR_W'(REGION_BYTES);

   // controller states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_HRD   = 4'd1;
   localparam logic [3:0] S_HUSE  = 4'd2;
   localparam logic [3:0] S_LUSE  = 4'd3;
   localparam logic [3:0] S_CPICK = 4'd4;
   localparam logic [3:0] S_CRD   = 4'd5;
   localparam logic [3:0] S_CUSE  = 4'd6;
   localparam logic [3:0] S_DONE  = 4'd7;

   logic [3:0]             state_ff, state_in;
   logic                   kind_ff, kind_in;
   logic [ADDR_W-1:0]      faddr_ff, faddr_in;
   logic [CLASS_W-1:0]     cls_ff, cls_in;
   logic [GRANT_W-1:0]     need_ff, need_in;
   logic [CLASS_W-1:0]     pick_ff, pick_in;
   logic [GRANT_W-1:0]     pbytes_ff, pbytes_in;
   logic [CLASS_COUNT-1:0] hv_ff, hv_in;
   logic [RGN_W-1:0]       open_ff, open_in;
   logic [OFS_W-1:0]       ofs_ff, ofs_in;
   logic [ADDR_W-1:0]      base_ff, base_in;
   logic [ADDR_W-1:0]      waste_ff, waste_in;
   logic [ADDR_W-1:0]      gaddr_ff, gaddr_in;
   logic [GRANT_W-1:0]     gbytes_ff, gbytes_in;
   logic [STATUS_W-1:0]    stat_ff, stat_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;

   logic                   head_we;
   logic [CLASS_W-1:0]     head_waddr, head_raddr;
   logic [ADDR_W-1:0]      head_wdata, head_rdata;
   logic                   link_we;
   logic [LINK_AW-1:0]     link_waddr;
   logic [ADDR_W:0]        link_wdata, link_rdata;

   logic [OFS_W-1:0]       rest;
   logic [ADDR_W-1:0]      bump_addr;
   logic [ADDR_W:0]        waste_sum;
   logic                   req_take;

   // list head and link memories
   scpa_ram #(.WIDTH(ADDR_W), .DEPTH(CLASS_COUNT)) u_heads (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_addr (head_raddr),
      .rd_data (head_rdata)
   );

   scpa_ram #(.WIDTH(ADDR_W + 1), .DEPTH(2 ** LINK_AW)) u_links (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (head_rdata[LINK_AW+1:2]),
      .rd_data (link_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rest      = RB_OFS - ofs_ff;
   assign bump_addr = base_ff + ADDR_W'(ofs_ff);
   assign waste_sum = {1'b0, waste_ff} + (ADDR_W+1)'(rest);
   assign head_raddr = (state_ff == S_CRD || state_ff == S_CUSE) ? pick_ff : cls_ff;

   // controller
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      faddr_in     = faddr_ff;
      cls_in       = cls_ff;
      need_in      = need_ff;
      pick_in      = pick_ff;
      pbytes_in    = pbytes_ff;
      hv_in        = hv_ff;
      open_in      = open_ff;
      ofs_in       = ofs_ff;
      base_in      = base_ff;
      waste_in     = waste_ff;
      gaddr_in     = gaddr_ff;
      gbytes_in    = gbytes_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      head_we      = 1'b0;
      head_waddr   = cls_ff;
      head_wdata   = faddr_ff;
      link_we      = 1'b0;
      link_waddr   = faddr_ff[LINK_AW+1:2];
      link_wdata   = {hv_ff[cls_ff], head_rdata};

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               kind_in   = req_word.req_type;
               faddr_in  = {req_word.piece_address[ADDR_W-1:2], 2'b00};
               cls_in    = class_for(req_word.request_bytes[GRANT_W-1:0]);
               need_in   = class_bytes(class_for(req_word.request_bytes[GRANT_W-1:0]));
               gaddr_in  = '0;
               gbytes_in = '0;
               if (req_word.request_bytes == '0) begin
                  stat_in  = ST_ZERO;
                  state_in = S_DONE;
               end else if (req_word.request_bytes > BYTES_W'(LARGEST_PIECE)) begin
                  stat_in  = ST_TOO_LARGE;
                  state_in = S_DONE;
               end else begin
                  state_in = S_HRD;
               end
            end
         end
         S_HRD: begin
            state_in = S_HUSE;
         end
         S_HUSE: begin
            if (kind_ff == KIND_FREE) begin
               // push the freed piece
               link_we     = 1'b1;
               head_we     = 1'b1;
               hv_in[cls_ff] = 1'b1;
               stat_in     = ST_FREED;
               state_in    = S_DONE;
            end else if (hv_ff[cls_ff]) begin
               // pop: link read goes out this cycle
               gaddr_in  = head_rdata;
               gbytes_in = need_ff;
               stat_in   = ST_ALLOCATED;
               state_in  = S_LUSE;
            end else if (open_ff != '0 && rest >= OFS_W'(need_ff)) begin
               // bump in the open region
               gaddr_in  = bump_addr;
               gbytes_in = need_ff;
               ofs_in    = ofs_ff + OFS_W'(need_ff);
               stat_in   = ST_ALLOCATED;
               state_in  = S_DONE;
            end else if (open_ff >= RGN_W'(REGION_COUNT)) begin
               stat_in  = ST_EXHAUSTED;
               state_in = S_DONE;
            end else if (open_ff != '0) begin
               state_in = S_CPICK;
            end else begin
               // first region
               open_in   = open_ff + RGN_W'(1);
               base_in   = '0;
               ofs_in    = OFS_W'(need_ff);
               gaddr_in  = '0;
               gbytes_in = need_ff;
               stat_in   = ST_ALLOCATED;
               state_in  = S_DONE;
            end
         end
         S_LUSE: begin
            // head takes the popped piece's link
            head_we       = 1'b1;
            head_wdata    = link_rdata[ADDR_W-1:0];
            hv_in[cls_ff] = link_rdata[ADDR_W];
            state_in      = S_DONE;
         end
         S_CPICK: begin
            if (rest < OFS_W'(SMALLEST_PIECE)) begin
               // tail done: count waste, open the next region and grant from its start
               waste_in  = waste_sum[ADDR_W] ? WASTE_MAX : waste_sum[ADDR_W-1:0];
               open_in   = open_ff + RGN_W'(1);
               base_in   = base_ff + RB_ADDR;
               ofs_in    = OFS_W'(need_ff);
               gaddr_in  = base_ff + RB_ADDR;
               gbytes_in = need_ff;
               stat_in   = ST_ALLOCATED;
               state_in  = S_DONE;
            end else begin
               pick_in   = pick_class(REST_W'(rest));
               pbytes_in = class_bytes(pick_class(REST_W'(rest)));
               state_in  = S_CRD;
            end
         end
         S_CRD: begin
            state_in = S_CUSE;
         end
         S_CUSE: begin
            // push the carved piece
            link_we        = 1'b1;
            link_waddr     = bump_addr[LINK_AW+1:2];
            link_wdata     = {hv_ff[pick_ff], head_rdata};
            head_we        = 1'b1;
            head_waddr     = pick_ff;
            head_wdata     = bump_addr;
            hv_in[pick_ff] = 1'b1;
            ofs_in         = ofs_ff + OFS_W'(pbytes_ff);
            state_in       = S_CPICK;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_word_in.granted_address = gaddr_ff;
               rsp_word_in.granted_bytes   = gbytes_ff;
               rsp_word_in.status          = stat_ff;
               rsp_word_in.wasted_total    = waste_ff;
               state_in                    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hv_ff        <= '0;
         open_ff      <= '0;
         ofs_ff       <= '0;
         base_ff      <= '0;
         waste_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hv_ff        <= hv_in;
         open_ff      <= open_in;
         ofs_ff       <= ofs_in;
         base_ff      <= base_in;
         waste_ff     <= waste_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      faddr_ff    <= faddr_in;
      cls_ff      <= cls_in;
      need_ff     <= need_in;
      pick_ff     <= pick_in;
      pbytes_ff   <= pbytes_in;
      gaddr_ff    <= gaddr_in;
      gbytes_ff   <= gbytes_in;
      stat_ff     <= stat_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // checks
   a_waste_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> waste_ff >= $past(waste_ff))
      else $error("waste count decreased");

   a_region_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff <= RGN_W'(REGION_COUNT))
      else $error("region count past pool");

   a_carve_fits: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CUSE |-> ({1'b0, ofs_ff} + (OFS_W+1)'(pbytes_ff)) <= (OFS_W+1)'(RB_OFS))
      else $error("carved piece runs past region end");

   a_grant_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.status == ST_ALLOCATED |-> rsp_word_ff.granted_bytes != '0)
      else $error("allocation without size");

endmodule

>>> rtl/core/scpa_ram.sv
// generic single write port, single read port ram with registered read
module scpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
